[sv/aabb_pair_collision_resolve_core_macros.svh]
// Assertion macros shared by the box-pair collision resolver RTL.
// Used by the top level only; needs a clock and an active-high reset argument.
`ifndef AABB_PAIR_COLLISION_RESOLVE_CORE_MACROS_SVH
`define AABB_PAIR_COLLISION_RESOLVE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apcr assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define APCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apcr assertion failed: next-cycle check");

`endif

[sv/apcr_pkg.sv]
// Shared types and constants for the box-pair collision resolver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package apcr_pkg;

   localparam int DEFAULT_FRAC_BITS = 16;

   localparam int CENTER_W = 32;   // signed center coordinate
   localparam int WSUM_W   = 31;   // summed widths, unsigned
   localparam int DIFF_W   = 33;   // center difference, signed
   localparam int MAG_W    = 33;   // magnitude of the difference
   localparam int OV_W     = 35;   // doubled overlap, signed
   localparam int PEN_W    = 31;   // penetration depth
   localparam int SHIFT_W  = 32;   // signed push
   localparam int BIAS_W   = 16;   // bias threshold register

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Per-axis overlap info handed from the overlap units to the resolver.
   typedef struct packed {
      logic signed [OV_W-1:0] ov;     // width_sum - 2|d|
      logic                   d_pos;  // d > 0
      logic                   d_neg;  // d < 0
   } ovl_type;

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_a_x;
      logic signed [CENTER_W-1:0] center_a_y;
      logic signed [CENTER_W-1:0] center_a_z;
      logic signed [CENTER_W-1:0] center_b_x;
      logic signed [CENTER_W-1:0] center_b_y;
      logic signed [CENTER_W-1:0] center_b_z;
      logic [WSUM_W-1:0]          width_sum_x;
      logic [WSUM_W-1:0]          width_sum_y;
      logic [WSUM_W-1:0]          width_sum_z;
      logic                       a_fixed;
      logic                       b_fixed;
   } req_type;

   typedef struct packed {
      logic                      collides;
      axis_type                  normal_axis;
      logic                      normal_negative;
      logic [PEN_W-1:0]          penetration;
      logic signed [SHIFT_W-1:0] shift_a;
      logic signed [SHIFT_W-1:0] shift_b;
      logic                      rest_a;
      logic                      rest_b;
   } rsp_type;

endpackage

[sv/apcr_overlap.sv]
// Per-axis doubled overlap of two boxes: width_sum - 2*|center_b - center_a|.
// Depends on apcr_pkg.
`timescale 1ns / 1ps

module apcr_overlap
   import apcr_pkg::*;
(
   input  logic signed [CENTER_W-1:0] center_a,
   input  logic signed [CENTER_W-1:0] center_b,
   input  logic [WSUM_W-1:0]          width_sum,
   output ovl_type                    ovl
);

   logic signed [DIFF_W-1:0] diff;
   logic [MAG_W-1:0]         mag;

   assign diff = DIFF_W'(center_b) - DIFF_W'(center_a);
   assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

   always_comb begin
      ovl.ov    = $signed({{(OV_W-WSUM_W){1'b0}}, width_sum})
                - $signed({1'b0, mag, 1'b0});
      ovl.d_neg = diff[DIFF_W-1];
      ovl.d_pos = !diff[DIFF_W-1] && (diff != '0);
   end

endmodule

[sv/apcr_resolve.sv]
// Axis choice, normal sign and push split for one box pair.
// Depends on apcr_pkg; fed by three apcr_overlap units.
`timescale 1ns / 1ps

module apcr_resolve
   import apcr_pkg::*;
(
   input  ovl_type           ovl [3],
   input  logic              a_fixed,
   input  logic              b_fixed,
   input  logic [BIAS_W-1:0] bias,
   output rsp_type           rsp
);

   localparam int OW = PEN_W;  // non-negative overlaps fit in 31 bits

   logic          hit;
   logic [OW-1:0] o0, o1, o2, b2, m1, mn;
   logic          y_take, z_take;
   axis_type      ax1, ax;
   logic          neg;
   logic [OW:0]   pen_sum, half_sum;
   logic [OW-1:0] pen, half, push_mag;
   logic signed [SHIFT_W-1:0] push;

   always_comb begin
      hit = !ovl[0].ov[OV_W-1] && !ovl[1].ov[OV_W-1] && !ovl[2].ov[OV_W-1];
      o0  = ovl[0].ov[OW-1:0];
      o1  = ovl[1].ov[OW-1:0];
      o2  = ovl[2].ov[OW-1:0];
      b2  = OW'({bias, 1'b0});

      // y wins on less-or-equal, or when both it and x are small
      y_take = (o1 <= o0) || ((o0 <= b2) && (o1 <= b2));
      m1     = y_take ? o1 : o0;
      ax1    = y_take ? AXIS_Y : AXIS_X;

      // z never displaces a small minimum with a smaller-than-bias overlap
      z_take = (o2 <= m1) && !((o2 < b2) && (m1 <= b2));
      mn     = z_take ? o2 : m1;
      ax     = z_take ? AXIS_Z : ax1;

      unique case (ax)
         AXIS_X:  neg = a_fixed ? ovl[0].d_neg : ovl[0].d_pos;
         AXIS_Y:  neg = a_fixed ? ovl[1].d_neg : ovl[1].d_pos;
         AXIS_Z:  neg = a_fixed ? ovl[2].d_neg : ovl[2].d_pos;
         default: neg = 1'b0;
      endcase

      pen_sum  = {1'b0, mn} + (OW+1)'(1);
      half_sum = {1'b0, mn} + (OW+1)'(2);
      pen      = pen_sum[OW:1];
      half     = OW'(half_sum[OW:2]);
      push_mag = (a_fixed || b_fixed) ? pen : half;
      push     = neg ? -$signed(SHIFT_W'(push_mag)) : $signed(SHIFT_W'(push_mag));

      rsp = '0;
      if (hit) begin
         rsp.collides        = 1'b1;
         rsp.normal_axis     = ax;
         rsp.normal_negative = neg;
         rsp.penetration     = pen;
         priority if (a_fixed) begin
            rsp.shift_b = push;
            rsp.rest_b  = 1'b1;
         end else if (b_fixed) begin
            rsp.shift_a = push;
            rsp.rest_a  = 1'b1;
         end else begin
            rsp.shift_a = push;
            rsp.shift_b = -push;
         end
      end
   end

endmodule

[sv/aabb_pair_collision_resolve_core.sv]
// Top level of the box-pair collision resolver: handshake, registers, config.
// Depends on apcr_pkg, apcr_overlap, apcr_resolve and the macros header.
`timescale 1ns / 1ps
`include "aabb_pair_collision_resolve_core_macros.svh"

// Box-pair collision resolver. Each transfer on the req_ channel carries one
// pair of axis-aligned boxes (Q16.16 centers, summed widths per axis, fixed
// flags); each pair produces exactly one transfer on the rsp_ channel with the
// collision flag, the least-overlap axis (small-overlap bias applied from the
// csr_ register), the normal sign, the penetration depth and the push of each
// box. Throughput is one pair per clock while rsp_stall is low; each req_
// transfer reaches rsp_valid via the input register and the result register
// around one pass of overlap, axis choice and push arithmetic. The result
// register doubles as a skid stage: while a result is stalled, one more pair
// is taken into the input register. Write csr_ only while the block is idle.
// FRAC_BITS only sets the reset value of the bias threshold (0.03 in fixed
// point, saturated to 16 bits).
module aabb_pair_collision_resolve_core
   import apcr_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_write_enable,
   input  logic [BIAS_W-1:0]          csr_write_data,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [CENTER_W-1:0] req_center_a_x,
   input  logic signed [CENTER_W-1:0] req_center_a_y,
   input  logic signed [CENTER_W-1:0] req_center_a_z,
   input  logic signed [CENTER_W-1:0] req_center_b_x,
   input  logic signed [CENTER_W-1:0] req_center_b_y,
   input  logic signed [CENTER_W-1:0] req_center_b_z,
   input  logic [WSUM_W-1:0]          req_width_sum_x,
   input  logic [WSUM_W-1:0]          req_width_sum_y,
   input  logic [WSUM_W-1:0]          req_width_sum_z,
   input  logic                       req_a_fixed,
   input  logic                       req_b_fixed,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_collides,
   output logic [1:0]                 rsp_normal_axis,
   output logic                       rsp_normal_negative,
   output logic [PEN_W-1:0]           rsp_penetration,
   output logic signed [SHIFT_W-1:0]  rsp_shift_a,
   output logic signed [SHIFT_W-1:0]  rsp_shift_b,
   output logic                       rsp_rest_a,
   output logic                       rsp_rest_b
);

   // 0.03 in fixed point, rounded down, saturated to the register width
   localparam int unsigned BIAS_RAW = (3 << FRAC_BITS) / 100;
   localparam int unsigned BIAS_MAX = (1 << BIAS_W) - 1;
   localparam logic [BIAS_W-1:0] BIAS_RESET =
      (BIAS_RAW > BIAS_MAX) ? BIAS_W'(BIAS_MAX) : BIAS_W'(BIAS_RAW);

   logic [BIAS_W-1:0] bias_ff, bias_in;

   // input register
   req_type req_ff, req_in;
   logic    s1_valid_ff, s1_valid_in;

   // result register
   rsp_type rsp_ff, rsp_in;
   logic    s2_valid_ff, s2_valid_in;

   logic    req_take;
   logic    s2_free;
   logic    s1_move;
   ovl_type ovl [3];
   rsp_type rsp_calc;

   // Handshake: the result register frees up when empty or when its transfer
   // completes; the input register drains into it whenever it is free.
   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      bias_in = csr_write_enable ? csr_write_data : bias_ff;

      req_in = req_ff;
      if (req_take) begin
         req_in.center_a_x  = req_center_a_x;
         req_in.center_a_y  = req_center_a_y;
         req_in.center_a_z  = req_center_a_z;
         req_in.center_b_x  = req_center_b_x;
         req_in.center_b_y  = req_center_b_y;
         req_in.center_b_z  = req_center_b_z;
         req_in.width_sum_x = req_width_sum_x;
         req_in.width_sum_y = req_width_sum_y;
         req_in.width_sum_z = req_width_sum_z;
         req_in.a_fixed     = req_a_fixed;
         req_in.b_fixed     = req_b_fixed;
      end
      // hold the input register when its item cannot advance
      s1_valid_in = req_take || (s1_valid_ff && !s2_free);

      rsp_in      = s1_move ? rsp_calc : rsp_ff;
      s2_valid_in = s1_move || (s2_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff     <= BIAS_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         bias_ff     <= bias_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload carries no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // One overlap unit per axis, all working on the held pair
   apcr_overlap u_overlap_x (
      .center_a  (req_ff.center_a_x),
      .center_b  (req_ff.center_b_x),
      .width_sum (req_ff.width_sum_x),
      .ovl       (ovl[0])
   );

   apcr_overlap u_overlap_y (
      .center_a  (req_ff.center_a_y),
      .center_b  (req_ff.center_b_y),
      .width_sum (req_ff.width_sum_y),
      .ovl       (ovl[1])
   );

   apcr_overlap u_overlap_z (
      .center_a  (req_ff.center_a_z),
      .center_b  (req_ff.center_b_z),
      .width_sum (req_ff.width_sum_z),
      .ovl       (ovl[2])
   );

   // Pick the axis, sign the normal and split the push
   apcr_resolve u_resolve (
      .ovl     (ovl),
      .a_fixed (req_ff.a_fixed),
      .b_fixed (req_ff.b_fixed),
      .bias    (bias_ff),
      .rsp     (rsp_calc)
   );

   assign rsp_valid           = s2_valid_ff;
   assign rsp_collides        = rsp_ff.collides;
   assign rsp_normal_axis     = rsp_ff.normal_axis;
   assign rsp_normal_negative = rsp_ff.normal_negative;
   assign rsp_penetration     = rsp_ff.penetration;
   assign rsp_shift_a         = rsp_ff.shift_a;
   assign rsp_shift_b         = rsp_ff.shift_b;
   assign rsp_rest_a          = rsp_ff.rest_a;
   assign rsp_rest_b          = rsp_ff.rest_b;

   // A miss clears every other result field
   `APCR_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_collides, (rsp_penetration == '0) && (rsp_shift_a == '0) && (rsp_shift_b == '0) && !rsp_rest_a && !rsp_rest_b && (rsp_normal_axis == '0))
   // Only one box rests, and with rest_b set box A does not move
   `APCR_ASSERT_SAME(a_rest_split, clock, reset, rsp_valid && rsp_rest_b, !rsp_rest_a && (rsp_shift_a == '0))
   // Two movable boxes are pushed apart by equal amounts
   `APCR_ASSERT_SAME(a_push_sym, clock, reset, rsp_valid && rsp_collides && !rsp_rest_a && !rsp_rest_b, rsp_shift_a == -rsp_shift_b)
   // A held item that cannot advance is not lost from the input register
   `APCR_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff)

endmodule

[tb/sv/tb_aabb_pair_collision_resolve_core.sv]
// Self-checking testbench for aabb_pair_collision_resolve_core: box pairs in, contacts out.
// Depends on apcr_pkg and the core RTL; carries its own contact predictor.
`timescale 1ns / 1ps

module tb_aabb_pair_collision_resolve_core;
   import apcr_pkg::*;

   // Numeric bounds of the Q16.16 fields, held as 64-bit values for the arithmetic below.
   localparam longint CENTER_MAX = 64'sd2147483647;
   localparam longint CENTER_MIN = -64'sd2147483648;
   localparam longint WSUM_MAX   = 64'sd2147483647;
   // Bias threshold after reset: 0.03 in Q16.16, rounded down.
   localparam logic [BIAS_W-1:0] BIAS_AT_RESET = 16'((3 << DEFAULT_FRAC_BITS) / 100);
   localparam int RANDOM_PAIRS_PER_PHASE = 300;
   localparam int PHASE_COUNT            = 6;
   localparam int CYCLE_LIMIT            = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_write_enable = 1'b0;
   logic [BIAS_W-1:0] csr_write_data   = '0;

   // Pair currently offered on the req_ channel; each field goes to its own port.
   req_type drive_pair = '0;
   logic    req_valid  = 1'b0;
   logic    req_stall;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_collides;
   logic [1:0]                rsp_normal_axis;
   logic                      rsp_normal_negative;
   logic [PEN_W-1:0]          rsp_penetration;
   logic signed [SHIFT_W-1:0] rsp_shift_a;
   logic signed [SHIFT_W-1:0] rsp_shift_b;
   logic                      rsp_rest_a;
   logic                      rsp_rest_b;

   // Pairs waiting for the driver, and contacts predicted but not yet seen.
   req_type queued_pairs[$];
   rsp_type expected_contacts[$];

   // Predictor's copy of the bias register.
   logic [BIAS_W-1:0] bias_model = BIAS_AT_RESET;

   // Idle rates in percent; the main sequence changes them between phases.
   int unsigned pair_gap_pct      = 0;
   int unsigned contact_stall_pct = 0;

   int contact_errors = 0;
   int contacts_seen  = 0;
   int cycle_count    = 0;

   aabb_pair_collision_resolve_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_center_a_x      (drive_pair.center_a_x),
      .req_center_a_y      (drive_pair.center_a_y),
      .req_center_a_z      (drive_pair.center_a_z),
      .req_center_b_x      (drive_pair.center_b_x),
      .req_center_b_y      (drive_pair.center_b_y),
      .req_center_b_z      (drive_pair.center_b_z),
      .req_width_sum_x     (drive_pair.width_sum_x),
      .req_width_sum_y     (drive_pair.width_sum_y),
      .req_width_sum_z     (drive_pair.width_sum_z),
      .req_a_fixed         (drive_pair.a_fixed),
      .req_b_fixed         (drive_pair.b_fixed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_collides        (rsp_collides),
      .rsp_normal_axis     (rsp_normal_axis),
      .rsp_normal_negative (rsp_normal_negative),
      .rsp_penetration     (rsp_penetration),
      .rsp_shift_a         (rsp_shift_a),
      .rsp_shift_b         (rsp_shift_b),
      .rsp_rest_a          (rsp_rest_a),
      .rsp_rest_b          (rsp_rest_b)
   );

   always #6 clock = ~clock;

   // Contact predictor. Overlaps are kept doubled (width_sum - 2|d|) so every
   // comparison is exact; the bias limit is doubled to match.
   function automatic rsp_type resolve_contact(input req_type p, input logic [BIAS_W-1:0] thr);
      longint   ca[3];
      longint   cb[3];
      longint   ws[3];
      longint   dv[3];
      longint   ov[3];
      longint   thr2;
      longint   best;
      longint   o;
      longint   pen;
      longint   half;
      longint   sa;
      longint   sb;
      axis_type pick;
      axis_type cur;
      bit       have;
      bit       hit;
      bit       small_min;
      bit       neg;
      rsp_type  r;
      ca = '{longint'($signed(p.center_a_x)), longint'($signed(p.center_a_y)),
             longint'($signed(p.center_a_z))};
      cb = '{longint'($signed(p.center_b_x)), longint'($signed(p.center_b_y)),
             longint'($signed(p.center_b_z))};
      ws = '{longint'(p.width_sum_x), longint'(p.width_sum_y), longint'(p.width_sum_z)};
      r    = '0;
      thr2 = 2 * longint'(thr);
      have = 1'b0;
      hit  = 1'b1;
      best = 0;
      pick = AXIS_X;
      for (int i = 0; i < 3; i++) begin
         dv[i] = cb[i] - ca[i];
         ov[i] = ws[i] - 2 * (dv[i] < 0 ? -dv[i] : dv[i]);
      end
      // Walk x, y, z; any negative overlap ends the test as a miss.
      for (int i = 0; i < 3 && hit; i++) begin
         cur       = axis_type'(i);
         o         = ov[i];
         small_min = have && best <= thr2;
         if (o < 0) begin
            hit = 1'b0;
         end else if (!have || o <= best) begin
            // Keep a small minimum against an even smaller z overlap below the bias.
            if (!(cur == AXIS_Z && o < thr2 && small_min)) begin
               best = o;
               pick = cur;
               have = 1'b1;
            end
         end else if (cur == AXIS_Y && small_min && o <= thr2) begin
            // Prefer y over a smaller x while both sit within the bias.
            best = o;
            pick = cur;
         end
      end
      if (hit) begin
         // A fixed A flips the sense of the normal.
         neg  = p.a_fixed ? (dv[pick] < 0) : (dv[pick] > 0);
         pen  = (best + 1) >>> 1;
         half = (best + 2) >>> 2;
         sa   = 0;
         sb   = 0;
         if (p.a_fixed) begin
            sb        = neg ? -pen : pen;
            r.rest_b  = 1'b1;
         end else if (p.b_fixed) begin
            sa        = neg ? -pen : pen;
            r.rest_a  = 1'b1;
         end else begin
            sa = neg ? -half : half;
            sb = -sa;
         end
         r.collides        = 1'b1;
         r.normal_axis     = pick;
         r.normal_negative = neg;
         r.penetration     = 31'(pen);
         r.shift_a         = 32'(sa);
         r.shift_b         = 32'(sb);
      end
      return r;
   endfunction

   // Build a pair from per-axis center differences (B - A) and doubled overlaps.
   // Place A at random and pull it toward the origin when B would leave 32 bits.
   function automatic req_type make_pair(input longint dx, dy, dz, ox, oy, oz,
                                         input bit af, bf);
      req_type p;
      longint  dv[3];
      longint  ov[3];
      longint  ws[3];
      longint  ca[3];
      longint  cb[3];
      dv = '{dx, dy, dz};
      ov = '{ox, oy, oz};
      for (int i = 0; i < 3; i++) begin
         ws[i] = ov[i] + 2 * (dv[i] < 0 ? -dv[i] : dv[i]);
         if (ws[i] < 0) ws[i] = 0;
         if (ws[i] > WSUM_MAX) ws[i] = WSUM_MAX;
         ca[i] = longint'($signed($urandom));
         cb[i] = ca[i] + dv[i];
         if (cb[i] > CENTER_MAX || cb[i] < CENTER_MIN) begin
            ca[i] = -(dv[i] >>> 1);
            cb[i] = ca[i] + dv[i];
         end
      end
      p.center_a_x  = 32'(ca[0]);
      p.center_a_y  = 32'(ca[1]);
      p.center_a_z  = 32'(ca[2]);
      p.center_b_x  = 32'(cb[0]);
      p.center_b_y  = 32'(cb[1]);
      p.center_b_z  = 32'(cb[2]);
      p.width_sum_x = 31'(ws[0]);
      p.width_sum_y = 31'(ws[1]);
      p.width_sum_z = 31'(ws[2]);
      p.a_fixed     = af;
      p.b_fixed     = bf;
      return p;
   endfunction

   // Random pair. Most pairs overlap on every axis, with overlaps clustered
   // around the bias limit and shared between axes so the axis rules get exercised;
   // some miss on exactly one axis, and a few are raw noise.
   function automatic req_type random_pair();
      req_type     p;
      longint      dl[3];
      longint      ol[3];
      longint      mag;
      longint      cap;
      longint      tie;
      int unsigned flavor;
      int unsigned miss_axis;
      int unsigned pick;
      flavor = $urandom_range(0, 99);
      if (flavor < 10) begin
         p.center_a_x  = $urandom;
         p.center_a_y  = $urandom;
         p.center_a_z  = $urandom;
         p.center_b_x  = $urandom;
         p.center_b_y  = $urandom;
         p.center_b_z  = $urandom;
         p.width_sum_x = 31'($urandom);
         p.width_sum_y = 31'($urandom);
         p.width_sum_z = 31'($urandom);
         p.a_fixed     = 1'($urandom);
         p.b_fixed     = 1'($urandom);
         return p;
      end
      tie       = longint'($urandom_range(0, 32'(bias_model) * 3 + 3));
      miss_axis = (flavor < 22) ? $urandom_range(0, 2) : 3;
      for (int i = 0; i < 3; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) mag = longint'($urandom_range(0, 1 << 16));
         else if (pick < 8) mag = longint'($urandom_range(0, 1 << 29));
         else if (pick == 8) mag = 0;
         else mag = longint'($urandom_range(0, 16));
         cap  = WSUM_MAX - 2 * mag;
         pick = $urandom_range(0, 9);
         if (pick < 4) ol[i] = longint'($urandom_range(0, 32'(bias_model) * 2 + 2));
         else if (pick < 6) ol[i] = tie;
         else if (pick < 8) ol[i] = longint'($urandom_range(0, 1 << 22));
         else ol[i] = longint'($urandom_range(0, 32'(cap)));
         if (i == miss_axis) begin
            ol[i] = -longint'($urandom_range(1, 5000));
            mag   = mag + 4000;
         end
         dl[i] = $urandom_range(0, 1) ? -mag : mag;
      end
      return make_pair(dl[0], dl[1], dl[2], ol[0], ol[1], ol[2],
                       $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
   endfunction

   // Append one pair to the driver's queue.
   task automatic enqueue_pair(input req_type p);
      queued_pairs = {queued_pairs, p};
   endtask

   // Directed pairs, written for the bias limit after reset (doubled: 3932).
   task automatic load_directed_pairs();
      req_type p;
      // Zero overlap everywhere, then the widest boxes under every fixed combination.
      enqueue_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
      for (int f = 0; f < 4; f++)
         enqueue_pair(make_pair(0, 0, 0, WSUM_MAX, WSUM_MAX, WSUM_MAX, f[0], f[1]));
      // Centers at opposite extremes: the difference spans 33 bits, so x misses.
      p = make_pair(0, 0, 0, WSUM_MAX, 10, 10, 1'b0, 1'b0);
      p.center_a_x = 32'(CENTER_MIN);
      p.center_b_x = 32'(CENTER_MAX);
      enqueue_pair(p);
      p.center_a_x = 32'(CENTER_MAX);
      p.center_b_x = 32'(CENTER_MIN);
      enqueue_pair(p);
      // Both centers pinned at the extremes on y and z, still a hit.
      p = make_pair(7, 0, 0, 40, 30, 20, 1'b0, 1'b1);
      p.center_a_y = 32'(CENTER_MIN);
      p.center_b_y = 32'(CENTER_MIN);
      p.center_a_z = 32'(CENTER_MAX);
      p.center_b_z = 32'(CENTER_MAX);
      enqueue_pair(p);
      // A miss by one unit on each axis in turn, then a touch with zero overlap.
      enqueue_pair(make_pair(10, -10, 10, -1, 50, 50, 1'b0, 1'b0));
      enqueue_pair(make_pair(10, -10, 10, 50, -1, 50, 1'b1, 1'b0));
      enqueue_pair(make_pair(10, -10, 10, 50, 50, -1, 1'b0, 1'b1));
      enqueue_pair(make_pair(-10, 20, 30, 0, 100, 100, 1'b1, 1'b0));
      // Axis choice: y beats a smaller x inside the bias; not once y is past it.
      enqueue_pair(make_pair(5, -7, 9, 100, 2000, 5000, 1'b0, 1'b0));
      enqueue_pair(make_pair(5, -7, 9, 100, 4000, 5000, 1'b0, 1'b1));
      // Smaller z below the bias does not displace a small minimum.
      enqueue_pair(make_pair(5, -7, 9, 500, 300, 200, 1'b0, 1'b0));
      // All three equal to the bias limit: ties move the choice on to z.
      enqueue_pair(make_pair(3, -3, 3, 3932, 3932, 3932, 1'b1, 1'b0));
      // Smaller z wins when the minimum is above the bias.
      enqueue_pair(make_pair(-5, 7, -9, 10000, 9000, 100, 1'b0, 1'b0));
      // Normal sign and push split: fixed A with both signs and with zero difference, fixed B, both fixed.
      enqueue_pair(make_pair(-100, 50, 50, 1, 900000, 900000, 1'b1, 1'b0));
      enqueue_pair(make_pair(100, 50, 50, 1, 900000, 900000, 1'b1, 1'b0));
      enqueue_pair(make_pair(-100, 50, 50, 9, 900000, 900000, 1'b0, 1'b1));
      enqueue_pair(make_pair(100, 50, 50, 9, 900000, 900000, 1'b1, 1'b1));
      enqueue_pair(make_pair(0, 50, 50, 9, 900000, 900000, 1'b1, 1'b0));
      // Rounding of penetration and half push on odd and tiny overlaps.
      enqueue_pair(make_pair(1, 1, 1, 7, 1000000, 1000000, 1'b0, 1'b0));
      enqueue_pair(make_pair(-1, 1, 1, 1, 1000000, 1000000, 1'b0, 1'b0));
      enqueue_pair(make_pair(-1, 1, 1, 2, 1000000, 1000000, 1'b0, 1'b0));
      enqueue_pair(make_pair(0, 0, 0, 6, 6, 9, 1'b0, 1'b0));
   endtask

   // Write the bias register; call only with the block idle.
   task automatic write_bias(input logic [BIAS_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bias_model = value;
      @(negedge clock);
   endtask

   // Wait at falling edges until every pair is sent and every contact checked.
   // One result per pair, so a short settle is enough afterwards.
   task automatic drain();
      do
         @(negedge clock);
      while (queued_pairs.size() != 0 || req_valid || expected_contacts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Print one line per mismatch and count it.
   task automatic report_contact(input string msg);
      $display("%s", msg);
      contact_errors++;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want)
         report_contact($sformatf("contact %0d %s: got %0d, expected %0d",
                                  contacts_seen, name, got, want));
   endtask

   // Driver: launch a new pair once the previous transfer is done; hold a
   // stalled pair unchanged. Idle at random as the current phase asks.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (queued_pairs.size() != 0 && $urandom_range(0, 99) >= pair_gap_pct) begin
            drive_pair <= queued_pairs.pop_front();
            req_valid  <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < contact_stall_pct;
      end
   end

   // Monitor: predict on each req_ transfer, check each rsp_ transfer against
   // the oldest prediction. Values read here are the ones before this edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_contacts = {expected_contacts, resolve_contact(drive_pair, bias_model)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_contacts.size() == 0) begin
               report_contact($sformatf("contact %0d arrived with no pair outstanding",
                                        contacts_seen));
            end else begin
               want = expected_contacts.pop_front();
               check_field("collides", rsp_collides, want.collides);
               check_field("normal_axis", rsp_normal_axis, want.normal_axis);
               check_field("normal_negative", rsp_normal_negative, want.normal_negative);
               check_field("penetration", rsp_penetration, want.penetration);
               check_field("shift_a", rsp_shift_a, want.shift_a);
               check_field("shift_b", rsp_shift_b, want.shift_b);
               check_field("rest_a", rsp_rest_a, want.rest_a);
               check_field("rest_b", rsp_rest_b, want.rest_b);
            end
            contacts_seen++;
         end
      end
   end

   // Watchdog: drop out with a failure if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aabb_pair_collision_resolve_core: mismatch");
         $finish;
      end
   end

   // Main sequence. Phases 0-1: sender idles lightly, receiver stalls heavily;
   // phases 2-3 the reverse; phases 4-5 full rate. Each phase after the first
   // starts with a new bias setting, written while the block is idle.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase / 2)
            0: begin
               pair_gap_pct      = 17;
               contact_stall_pct = 69;
            end
            1: begin
               pair_gap_pct      = 69;
               contact_stall_pct = 17;
            end
            default: begin
               pair_gap_pct      = 0;
               contact_stall_pct = 0;
            end
         endcase
         case (phase)
            1: write_bias('0);
            2: write_bias('1);
            3: write_bias(16'($urandom_range(2, 65534)));
            4: write_bias(16'd1);
            5: write_bias(16'($urandom_range(0, 8000)));
            default: ;
         endcase
         if (phase == 0) load_directed_pairs();
         repeat (RANDOM_PAIRS_PER_PHASE) enqueue_pair(random_pair());
         drain();
      end
      if (contact_errors == 0) begin
         $display("aabb_pair_collision_resolve_core: match");
      end else begin
         $display("aabb_pair_collision_resolve_core: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/apcr_pkg.sv
sv/apcr_overlap.sv
sv/apcr_resolve.sv
sv/aabb_pair_collision_resolve_core.sv
tb/sv/tb_aabb_pair_collision_resolve_core.sv
